/* src/link_pair_jaccard_similarity_unit_macros.svh */
// assertion macros for the link pair jaccard similarity unit
`ifndef LINK_PAIR_JACCARD_SIMILARITY_UNIT_MACROS_SVH
`define LINK_PAIR_JACCARD_SIMILARITY_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LPJ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define LPJ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define LPJ_ASSERT(label, clk, rst_n, prop)
`define LPJ_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* src/lpj_pkg.sv */
// shared types and constants of the link pair jaccard similarity unit
package lpj_pkg;
  localparam int MaxEdges = 4096;
  localparam int NodeBits = 16;
  localparam int FracBits = 16;
  localparam int IdxBits  = $clog2(MaxEdges);
  localparam int CntBits  = $clog2(MaxEdges + 1);
  localparam int DegBits  = 13;
  localparam int UniBits  = 14;
  localparam int SimBits  = FracBits + 1;
  localparam int NumBits  = UniBits + FracBits;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoShare = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StRange   = 2'd3;

  // command word handed from the front to the back
  typedef struct packed {
    logic                walk;
    logic [1:0]          status;
    logic [NodeBits-1:0] far_a;
    logic [NodeBits-1:0] far_b;
    logic [NodeBits-1:0] key;
    logic [CntBits-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [NodeBits-1:0] far_a;
    logic [NodeBits-1:0] far_b;
    logic [NodeBits-1:0] key;
    logic [DegBits-1:0]  deg_a;
    logic [DegBits-1:0]  deg_b;
    logic [UniBits-1:0]  uni;
    logic [UniBits-1:0]  shared;
    logic [SimBits-1:0]  sim;
    logic [CntBits-1:0]  count;
  } res_t;
endpackage

/* src/lpj_front.sv */
// front: edge table, appends, query lookup and keystone classification
module lpj_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic                        func_i,
  input  logic [lpj_pkg::NodeBits-1:0] node_u_i,
  input  logic [lpj_pkg::NodeBits-1:0] node_v_i,
  input  logic [lpj_pkg::IdxBits-1:0]  edge_first_i,
  input  logic [lpj_pkg::IdxBits-1:0]  edge_second_i,
  input  logic                        walk_req_i,
  input  logic [lpj_pkg::IdxBits-1:0]  walk_idx_i,
  output logic [2*lpj_pkg::NodeBits-1:0] walk_edge_o,
  output logic                        cmd_valid_o,
  output lpj_pkg::cmd_t               cmd_o,
  output logic [lpj_pkg::CntBits-1:0] count_o
);
  import lpj_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRd2  = 2'd1;
  localparam logic [1:0] SCls  = 2'd2;

  logic [2*NodeBits-1:0] mem [MaxEdges];
  logic [CntBits-1:0]    count_q;
  logic [1:0]            state_q;
  logic [IdxBits-1:0]    idx2_q;
  logic [2*NodeBits-1:0] rd_q, e1_q;
  logic                  range_q;
  logic [NodeBits-1:0]   lo_w, hi_w;
  logic                  full_w, wr_w;
  logic [IdxBits-1:0]    rd_addr;
  logic [NodeBits-1:0]   a1, b1, a2, b2;

  assign full_w = (count_q == CntBits'(MaxEdges));
  assign wr_w   = take_i && !func_i && !full_w;
  assign lo_w   = (node_u_i < node_v_i) ? node_u_i : node_v_i;
  assign hi_w   = (node_u_i < node_v_i) ? node_v_i : node_u_i;

  always_comb begin
    if (walk_req_i) rd_addr = walk_idx_i;
    else if (state_q == SRd2) rd_addr = idx2_q;
    else rd_addr = edge_first_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_w) mem[count_q[IdxBits-1:0]] <= {lo_w, hi_w};
    rd_q <= mem[rd_addr];
  end
  assign walk_edge_o = rd_q;

  assign {a1, b1} = e1_q;
  assign {a2, b2} = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      state_q     <= SIdle;
      cmd_valid_o <= 1'b0;
      cmd_o       <= '0;
      idx2_q      <= '0;
      range_q     <= 1'b0;
      e1_q        <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          cmd_valid_o <= take_i && !func_i;
          if (take_i) begin
            if (!func_i) begin
              cmd_o <= '{walk: 1'b0, status: full_w ? StFull : StOk, far_a: '0,
                         far_b: '0, key: '0,
                         count: full_w ? count_q : count_q + 1'b1};
              if (wr_w) count_q <= count_q + 1'b1;
            end else begin
              idx2_q  <= edge_second_i;
              range_q <= (CntBits'(edge_first_i) >= count_q) ||
                         (CntBits'(edge_second_i) >= count_q);
              state_q <= SRd2;
            end
          end
        end
        SRd2: begin
          cmd_valid_o <= 1'b0;
          e1_q        <= rd_q;
          state_q     <= SCls;
        end
        SCls: begin
          cmd_valid_o <= 1'b1;
          state_q     <= SIdle;
          if (range_q) cmd_o <= '{1'b0, StRange, '0, '0, '0, count_q};
          else if (a1 == a2) cmd_o <= '{1'b1, StOk, b1, b2, a1, count_q};
          else if (b1 == b2) cmd_o <= '{1'b1, StOk, a1, a2, b1, count_q};
          else if (a1 == b2) cmd_o <= '{1'b1, StOk, b1, a2, a1, count_q};
          else if (b1 == a2) cmd_o <= '{1'b1, StOk, a1, b2, b1, count_q};
          else cmd_o <= '{1'b0, StNoShare, '0, '0, '0, count_q};
        end
        default: begin
          cmd_valid_o <= 1'b0;
          state_q     <= SIdle;
        end
      endcase
    end
  end
  assign count_o = count_q;
endmodule

/* src/lpj_queue.sv */
// two-entry command queue between front and back
module lpj_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lpj_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output lpj_pkg::cmd_t data_o
);
  import lpj_pkg::*;
  cmd_t       buf_q [2];
  logic       rp_q, wp_q;
  logic [1:0] n_q;

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0; wp_q <= 1'b0; n_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      n_q <= n_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
  assign valid_o = (n_q != 2'd0);
  assign data_o  = buf_q[rp_q];
endmodule

/* src/lpj_back.sv */
// back: neighborhood walk, visited map, clear pass and rounding divider
module lpj_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  lpj_pkg::cmd_t               cmd_i,
  output logic                        pop_o,
  output logic                        walk_req_o,
  output logic [lpj_pkg::IdxBits-1:0] walk_idx_o,
  input  logic [2*lpj_pkg::NodeBits-1:0] walk_edge_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  output lpj_pkg::res_t               res_o
);
  import lpj_pkg::*;
  `include "link_pair_jaccard_similarity_unit_macros.svh"

  localparam logic [4:0] SInit    = 5'd0;
  localparam logic [4:0] SIdle    = 5'd1;
  localparam logic [4:0] SMarkA   = 5'd2;
  localparam logic [4:0] SMarkB   = 5'd3;
  localparam logic [4:0] SFetch   = 5'd4;
  localparam logic [4:0] SLoad    = 5'd5;
  localparam logic [4:0] SChkA    = 5'd6;
  localparam logic [4:0] SSetA    = 5'd7;
  localparam logic [4:0] SChkB    = 5'd8;
  localparam logic [4:0] SSetB    = 5'd9;
  localparam logic [4:0] SClFetch = 5'd10;
  localparam logic [4:0] SClLo    = 5'd11;
  localparam logic [4:0] SClHi    = 5'd12;
  localparam logic [4:0] SClA     = 5'd13;
  localparam logic [4:0] SClB     = 5'd14;
  localparam logic [4:0] SDivI    = 5'd15;
  localparam logic [4:0] SDiv     = 5'd16;

  localparam logic [NumBits-1:0] SimOne = NumBits'(1) << FracBits;

  logic                vmap [2**NodeBits];
  logic [4:0]          state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [CntBits-1:0]  idx_q, idx_d;
  logic [NodeBits-1:0] lo_q, lo_d, hi_q, hi_d, clr_q, clr_d;
  logic [DegBits-1:0]  da_q, da_d, db_q, db_d;
  logic [UniBits-1:0]  un_q, un_d;
  logic [NumBits-1:0]  rem_q, rem_d, quo_q, quo_d;
  logic [4:0]          step_q, step_d;
  logic                res_valid_q, res_valid_d;
  res_t                res_q, res_d;
  logic [NodeBits-1:0] m_addr;
  logic                m_we, m_wd, m_rd_q;
  logic                hit_a, hit_b, at_end;
  logic [NodeBits-1:0] nb_a, nb_b;
  logic [UniBits-1:0]  shared_w;
  logic [NumBits-1:0]  numer_w;
  logic [NumBits:0]    trial_w;
  logic [SimBits-1:0]  sim_w;

  assign hit_a    = (lo_q == cmd_q.far_a) || (hi_q == cmd_q.far_a);
  assign hit_b    = (lo_q == cmd_q.far_b) || (hi_q == cmd_q.far_b);
  assign nb_a     = (lo_q == cmd_q.far_a) ? hi_q : lo_q;
  assign nb_b     = (lo_q == cmd_q.far_b) ? hi_q : lo_q;
  assign at_end   = (idx_q == cmd_q.count);
  assign shared_w = UniBits'(da_q) + UniBits'(db_q) - un_q;
  // rounding numerator (shared << frac) + un/2
  assign numer_w  = {shared_w, {FracBits{1'b0}}} + NumBits'(un_q >> 1);
  assign trial_w  = {rem_q, quo_q[NumBits-1]} - {{(NumBits+1-UniBits){1'b0}}, un_q};
  assign sim_w    = (quo_q > SimOne) ? SimOne[SimBits-1:0] : quo_q[SimBits-1:0];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    clr_d       = clr_q;
    da_d        = da_q;
    db_d        = db_q;
    un_d        = un_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    m_addr      = clr_q;
    m_we        = 1'b0;
    m_wd        = 1'b0;
    pop_o       = 1'b0;
    walk_req_o  = 1'b0;
    case (state_q)
      // clear the whole map once after reset
      SInit: begin
        m_we  = 1'b1;
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = SIdle;
      end
      SIdle: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          if (cmd_i.walk) begin
            da_d    = DegBits'(1);
            db_d    = DegBits'(1);
            un_d    = (cmd_i.far_a == cmd_i.far_b) ? UniBits'(1) : UniBits'(2);
            idx_d   = '0;
            state_d = SMarkA;
          end else begin
            res_valid_d  = 1'b1;
            res_d        = '0;
            res_d.status = cmd_i.status;
            res_d.count  = cmd_i.count;
          end
        end
      end
      // far ends start in the union, map is clear so no read needed
      SMarkA: begin
        m_addr  = cmd_q.far_a;
        m_we    = 1'b1;
        m_wd    = 1'b1;
        state_d = SMarkB;
      end
      SMarkB: begin
        m_addr  = cmd_q.far_b;
        m_we    = 1'b1;
        m_wd    = 1'b1;
        state_d = SFetch;
      end
      SFetch: begin
        if (at_end) begin
          idx_d   = '0;
          state_d = SClFetch;
        end else begin
          walk_req_o = 1'b1;
          state_d    = SLoad;
        end
      end
      SLoad: begin
        lo_d    = walk_edge_i[2*NodeBits-1:NodeBits];
        hi_d    = walk_edge_i[NodeBits-1:0];
        state_d = SChkA;
      end
      // neighbor test, map read issued here and checked next cycle
      SChkA: begin
        if (hit_a) begin
          da_d    = da_q + 1'b1;
          m_addr  = nb_a;
          state_d = SSetA;
        end else begin
          state_d = SChkB;
        end
      end
      SSetA: begin
        m_addr = nb_a;
        if (!m_rd_q) begin
          m_we = 1'b1;
          m_wd = 1'b1;
          un_d = un_q + 1'b1;
        end
        state_d = SChkB;
      end
      SChkB: begin
        if (hit_b) begin
          db_d    = db_q + 1'b1;
          m_addr  = nb_b;
          state_d = SSetB;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = SFetch;
        end
      end
      SSetB: begin
        m_addr = nb_b;
        if (!m_rd_q) begin
          m_we = 1'b1;
          m_wd = 1'b1;
          un_d = un_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = SFetch;
      end
      // clear pass over both ends of every stored edge
      SClFetch: begin
        if (at_end) begin
          state_d = SClA;
        end else begin
          walk_req_o = 1'b1;
          state_d    = SClLo;
        end
      end
      SClLo: begin
        m_addr  = walk_edge_i[2*NodeBits-1:NodeBits];
        m_we    = 1'b1;
        hi_d    = walk_edge_i[NodeBits-1:0];
        state_d = SClHi;
      end
      SClHi: begin
        m_addr  = hi_q;
        m_we    = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = SClFetch;
      end
      SClA: begin
        m_addr  = cmd_q.far_a;
        m_we    = 1'b1;
        state_d = SClB;
      end
      SClB: begin
        m_addr  = cmd_q.far_b;
        m_we    = 1'b1;
        state_d = SDivI;
      end
      SDivI: begin
        rem_d   = '0;
        quo_d   = numer_w;
        step_d  = 5'(NumBits);
        state_d = SDiv;
      end
      // restoring divider, one quotient bit per cycle
      SDiv: begin
        if (step_q == '0) begin
          res_valid_d = 1'b1;
          res_d = '{StOk, cmd_q.far_a, cmd_q.far_b, cmd_q.key, da_q, db_q, un_q,
                    shared_w, sim_w, cmd_q.count};
          state_d = SIdle;
        end else begin
          step_d = step_q - 1'b1;
          if (!trial_w[NumBits]) begin
            rem_d = trial_w[NumBits-1:0];
            quo_d = {quo_q[NumBits-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[NumBits-2:0], quo_q[NumBits-1]};
            quo_d = {quo_q[NumBits-2:0], 1'b0};
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (m_we) vmap[m_addr] <= m_wd;
    m_rd_q <= vmap[m_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SInit;
      cmd_q       <= '0;
      idx_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      clr_q       <= '0;
      da_q        <= '0;
      db_q        <= '0;
      un_q        <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      idx_q       <= idx_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      clr_q       <= clr_d;
      da_q        <= da_d;
      db_q        <= db_d;
      un_q        <= un_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign walk_idx_o  = idx_q[IdxBits-1:0];
  assign idle_o      = (state_q == SIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `LPJ_ASSERT(a_res_idle, clk_i, rst_ni, !res_valid_o || state_q == SIdle)
  `LPJ_ASSERT_NEXT(a_div_done, clk_i, rst_ni, state_q == SDiv && step_q == '0, res_valid_o)
  `LPJ_ASSERT(a_union_pos, clk_i, rst_ni, !(state_q == SDiv && un_q == '0))
  `LPJ_ASSERT(a_walk_range, clk_i, rst_ni, !walk_req_o || idx_q < cmd_q.count)
endmodule

/* src/link_pair_jaccard_similarity_unit.sv */
// top level of the link pair jaccard similarity unit
// an append passes the front command register, the queue and the back result register
// a rejected query passes SRd2 and SCls first; an ok query also walks, clears and divides
// throughput: one word at a time; busy stays high through the result strobe cycle
// reset (async, active low): table emptied, then busy while the back clears the whole map
module link_pair_jaccard_similarity_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [15:0] node_u_i,
  input  logic [15:0] node_v_i,
  input  logic [11:0] edge_first_i,
  input  logic [11:0] edge_second_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] far_node_a_o,
  output logic [15:0] far_node_b_o,
  output logic [15:0] keystone_node_o,
  output logic [12:0] degree_a_o,
  output logic [12:0] degree_b_o,
  output logic [13:0] union_size_o,
  output logic [13:0] shared_count_o,
  output logic [16:0] similarity_q16_o,
  output logic [12:0] edge_count_o
);
  import lpj_pkg::*;

  logic                  take, busy_q;
  logic                  cmd_v, q_v, pop, wreq, idle, rv;
  cmd_t                  cmd, qd;
  res_t                  res;
  logic [IdxBits-1:0]    widx;
  logic [2*NodeBits-1:0] wedge;
  logic [CntBits-1:0]    cnt;

  // one word in flight: busy from accept until its result strobe
  // the back is not idle during the map clear after reset, which holds busy too
  assign busy_o = busy_q || !idle;
  assign take   = start_i && !busy_o;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (take) busy_q <= 1'b1;
    else if (rv) busy_q <= 1'b0;
  end

  lpj_front u_front (
    .clk_i, .rst_ni, .take_i(take), .func_i, .node_u_i, .node_v_i,
    .edge_first_i, .edge_second_i, .walk_req_i(wreq), .walk_idx_i(widx),
    .walk_edge_o(wedge), .cmd_valid_o(cmd_v), .cmd_o(cmd), .count_o(cnt)
  );

  lpj_queue u_queue (
    .clk_i, .rst_ni, .push_i(cmd_v), .data_i(cmd), .pop_i(pop),
    .valid_o(q_v), .data_o(qd)
  );

  lpj_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_v), .cmd_i(qd), .pop_o(pop),
    .walk_req_o(wreq), .walk_idx_o(widx), .walk_edge_i(wedge),
    .idle_o(idle), .res_valid_o(rv), .res_o(res)
  );

  assign done_o           = rv;
  assign status_o         = res.status;
  assign far_node_a_o     = res.far_a;
  assign far_node_b_o     = res.far_b;
  assign keystone_node_o  = res.key;
  assign degree_a_o       = res.deg_a;
  assign degree_b_o       = res.deg_b;
  assign union_size_o     = res.uni;
  assign shared_count_o   = res.shared;
  assign similarity_q16_o = res.sim;
  assign edge_count_o     = (idle && !rv) ? cnt : res.count;
endmodule

/* sim/tb_link_pair_jaccard_similarity_unit.sv */
// testbench of the link pair jaccard similarity unit: predicted words checked at the strobe
`timescale 1ns / 1ps

module tb_link_pair_jaccard_similarity_unit;
  import lpj_pkg::*;

  localparam int IdleLimit = 400000;  // covers the map clear after reset, when no word is accepted

  typedef enum logic {FnAppend = 1'b0, FnQuery = 1'b1} func_e;

  typedef struct {
    func_e       fn;
    logic [15:0] u;
    logic [15:0] v;
    logic [11:0] first;
    logic [11:0] second;
  } cmd_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        func_i = 1'b0;
  logic [15:0] node_u_i = '0;
  logic [15:0] node_v_i = '0;
  logic [11:0] edge_first_i = '0;
  logic [11:0] edge_second_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] far_node_a_o;
  logic [15:0] far_node_b_o;
  logic [15:0] keystone_node_o;
  logic [12:0] degree_a_o;
  logic [12:0] degree_b_o;
  logic [13:0] union_size_o;
  logic [13:0] shared_count_o;
  logic [16:0] similarity_q16_o;
  logic [12:0] edge_count_o;

  link_pair_jaccard_similarity_unit i_dut (.*);

  always #10 clk_i = ~clk_i;

  // pending words, expected results and the shadow edge table
  cmd_word_t   pending_words[$];
  res_t        expected_results[$];
  logic [15:0] table_lo[MaxEdges];
  logic [15:0] table_hi[MaxEdges];
  int          table_count = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          ok_queries = 0;
  int          quiet_cycles = 0;

  // works out the result word for one accepted command word
  function automatic res_t jaccard_result(cmd_word_t w);
    res_t r;
    bit seen[int];
    int fa, fb, ks, da, db, un, sh;
    logic [15:0] a1, b1, a2, b2;
    longint num, sim;
    bit share;
    r = '0;
    if (w.fn == FnAppend) begin
      if (table_count >= MaxEdges) begin
        r.status = StFull;
      end else begin
        table_lo[table_count] = (w.u < w.v) ? w.u : w.v;
        table_hi[table_count] = (w.u < w.v) ? w.v : w.u;
        table_count++;
        r.status = StOk;
      end
    end else if (w.first >= table_count || w.second >= table_count) begin
      r.status = StRange;
    end else begin
      a1 = table_lo[w.first];  b1 = table_hi[w.first];
      a2 = table_lo[w.second]; b2 = table_hi[w.second];
      share = 1'b1;
      // keystone priority: lo/lo, hi/hi, lo/hi, hi/lo
      if (a1 == a2)      begin fa = b1; fb = b2; ks = a1; end
      else if (b1 == b2) begin fa = a1; fb = a2; ks = b1; end
      else if (a1 == b2) begin fa = b1; fb = a2; ks = a1; end
      else if (b1 == a2) begin fa = a1; fb = b2; ks = b1; end
      else share = 1'b0;
      if (!share) begin
        r.status = StNoShare;
      end else begin
        da = 1; db = 1; un = 0;
        seen[fa] = 1'b1; un++;
        if (!seen.exists(fb)) begin seen[fb] = 1'b1; un++; end
        for (int i = 0; i < table_count; i++) begin
          if (table_lo[i] == fa) begin
            da++;
            if (!seen.exists(table_hi[i])) begin seen[table_hi[i]] = 1'b1; un++; end
          end else if (table_hi[i] == fa) begin
            da++;
            if (!seen.exists(table_lo[i])) begin seen[table_lo[i]] = 1'b1; un++; end
          end
          if (table_lo[i] == fb) begin
            db++;
            if (!seen.exists(table_hi[i])) begin seen[table_hi[i]] = 1'b1; un++; end
          end else if (table_hi[i] == fb) begin
            db++;
            if (!seen.exists(table_lo[i])) begin seen[table_lo[i]] = 1'b1; un++; end
          end
        end
        sh = da + db - un;
        num = (longint'(sh) << FracBits) + longint'(un / 2);
        sim = num / un;
        if (sim > (longint'(1) << FracBits)) sim = longint'(1) << FracBits;
        r.status = StOk;
        r.far_a = 16'(fa); r.far_b = 16'(fb); r.key = 16'(ks);
        r.deg_a = DegBits'(da); r.deg_b = DegBits'(db);
        r.uni = UniBits'(un); r.shared = UniBits'(sh);
        r.sim = SimBits'(sim);
      end
    end
    r.count = CntBits'(table_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, field, got,
             want);
    mismatches++;
  endtask

  task automatic add_word(cmd_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // driver: start held until accepted, random gaps except in a burst window
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_word_t w;
    bit idle;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_results.insert(expected_results.size(),
          jaccard_result(cmd_word_t'{func_e'(func_i), node_u_i, node_v_i,
                                     edge_first_i, edge_second_i}));
        words_sent++;
      end
      if (!start_i || !busy_o) begin
        idle = (words_sent < 60 || words_sent >= 95) && ($urandom_range(99) < 35);
        if (pending_words.size() > 0 && !idle) begin
          w = pending_words.pop_front();
          func_i        <= w.fn;
          node_u_i      <= w.u;
          node_v_i      <= w.v;
          edge_first_i  <= w.first;
          edge_second_i <= w.second;
          start_i       <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (status_o != e.status) report_mismatch("status", status_o, e.status);
        if (far_node_a_o != e.far_a) report_mismatch("far_node_a", far_node_a_o, e.far_a);
        if (far_node_b_o != e.far_b) report_mismatch("far_node_b", far_node_b_o, e.far_b);
        if (keystone_node_o != e.key) report_mismatch("keystone", keystone_node_o, e.key);
        if (degree_a_o != e.deg_a) report_mismatch("degree_a", degree_a_o, e.deg_a);
        if (degree_b_o != e.deg_b) report_mismatch("degree_b", degree_b_o, e.deg_b);
        if (union_size_o != e.uni) report_mismatch("union_size", union_size_o, e.uni);
        if (shared_count_o != e.shared)
          report_mismatch("shared_count", shared_count_o, e.shared);
        if (similarity_q16_o != e.sim)
          report_mismatch("similarity_q16", similarity_q16_o, e.sim);
        if (edge_count_o != e.count) report_mismatch("edge_count", edge_count_o, e.count);
        if (e.status == StOk && e.uni != 0) ok_queries++;
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no accepted word in either direction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cmd_word_t append_word(logic [15:0] u, logic [15:0] v);
    return '{FnAppend, u, v, 12'd0, 12'd0};
  endfunction

  function automatic cmd_word_t query_word(logic [11:0] a, logic [11:0] b);
    return '{FnQuery, 16'($urandom()), 16'($urandom()), a, b};
  endfunction

  initial begin
    logic [15:0] node_pool[6];
    int shadow_count;
    // directed: empty table, extremes, duplicates, self loop, each keystone order
    add_word(query_word(12'd0, 12'd0));        // range on empty table
    add_word(append_word(16'hffff, 16'h0000)); // 0: (0,ffff)
    add_word(append_word(16'h0000, 16'hffff)); // 1: duplicate
    add_word(append_word(16'd5, 16'd5));       // 2: self loop
    add_word(append_word(16'd5, 16'd0));       // 3: (0,5)
    add_word(append_word(16'd100, 16'hffff));  // 4: (100,ffff)
    add_word(append_word(16'd9, 16'd5));       // 5: (5,9)
    add_word(query_word(12'd0, 12'd0));        // same edge twice
    add_word(query_word(12'd0, 12'd1));        // duplicate edges
    add_word(query_word(12'd0, 12'd3));        // low ends match
    add_word(query_word(12'd0, 12'd4));        // high ends match
    add_word(query_word(12'd5, 12'd3));        // first low, second high
    add_word(query_word(12'd3, 12'd5));        // first high, second low
    add_word(query_word(12'd2, 12'd2));        // self loop twice
    add_word(query_word(12'd2, 12'd4));        // no shared node
    add_word(query_word(12'd6, 12'd0));        // index equal to count
    add_word(query_word(12'd0, 12'hfff));      // top index
    shadow_count = 6;
    // random: small node pool so queried edges often share a node
    foreach (node_pool[i]) node_pool[i] = 16'($urandom());
    node_pool[0] = 16'h0000;
    node_pool[1] = 16'hffff;
    for (int n = 0; n < 83; n++) begin
      if ($urandom_range(99) < 35 || shadow_count < 2) begin
        add_word(append_word(
          ($urandom_range(9) == 0) ? 16'($urandom()) : node_pool[$urandom_range(5)],
          node_pool[$urandom_range(5)]));
        shadow_count++;
      end else if ($urandom_range(99) < 88) begin
        add_word(query_word(12'($urandom_range(shadow_count - 1)),
                            12'($urandom_range(shadow_count - 1))));
      end else begin
        add_word(query_word(12'($urandom()), 12'($urandom())));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("sent %0d words, checked %0d results, %0d of them ok queries with a walk",
             words_sent, results_seen, ok_queries);
    $display("edge table held %0d edges at the end of the run", table_count);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
